[hw/rtl/tnrn_pkg.sv]
// ----------------------------------------------------------------------------
// tnrn_pkg
// types and codes shared by the telnet receive negotiator
// ----------------------------------------------------------------------------
package tnrn_pkg;

  typedef enum logic [3:0] {
    ST_DATA      = 4'd0,
    ST_DATAR     = 4'd1,
    ST_DATAN     = 4'd2,
    ST_IAC       = 4'd3,
    ST_WILL      = 4'd4,
    ST_WONT      = 4'd5,
    ST_DO        = 4'd6,
    ST_DONT      = 4'd7,
    ST_SB        = 4'd8,
    ST_SBDATA    = 4'd9,
    ST_SBIAC     = 4'd10,
    ST_SBDATAIAC = 4'd11
  } parse_state_t;

  typedef enum logic [1:0] {
    RPL_NONE = 2'd0,
    RPL_OPT  = 2'd1,
    RPL_TTYPE = 2'd2
  } reply_kind_t;

  localparam logic [7:0] B_IAC  = 8'd255;
  localparam logic [7:0] B_DONT = 8'd254;
  localparam logic [7:0] B_DO   = 8'd253;
  localparam logic [7:0] B_WONT = 8'd252;
  localparam logic [7:0] B_WILL = 8'd251;
  localparam logic [7:0] B_SB   = 8'd250;
  localparam logic [7:0] B_SE   = 8'd240;
  localparam logic [7:0] B_EOR  = 8'd239;
  localparam logic [7:0] B_CR   = 8'd13;
  localparam logic [7:0] B_LF   = 8'd10;

  localparam logic [2:0] E_NONE = 3'd0;
  localparam logic [2:0] E_WILL = 3'd1;
  localparam logic [2:0] E_WONT = 3'd2;
  localparam logic [2:0] E_DO   = 3'd3;
  localparam logic [2:0] E_DONT = 3'd4;

  localparam logic [1:0] DEST_APP = 2'd0;
  localparam logic [1:0] DEST_NET = 2'd1;
  localparam logic [1:0] DEST_EVT = 2'd2;

  localparam logic [7:0] EVT_EOR      = 8'd0;
  localparam logic [7:0] EVT_ECHO_OFF = 8'd1;
  localparam logic [7:0] EVT_ECHO_ON  = 8'd2;

  localparam int NAME_MAX = 40;

  function automatic logic [7:0] term_char(input logic [5:0] i);
    logic [7:0] c;
    begin
      case (i)
        6'd0: c = 8'h53;
        6'd1: c = 8'h69;
        6'd2: c = 8'h72;
        6'd3: c = 8'h61;
        6'd4: c = 8'h67;
        6'd5: c = 8'h67;
        6'd6: c = 8'h61;
        6'd7: c = 8'h54;
        6'd8: c = 8'h65;
        6'd9: c = 8'h72;
        6'd10: c = 8'h6d;
        6'd11: c = 8'h69;
        6'd12: c = 8'h6e;
        6'd13: c = 8'h61;
        6'd14: c = 8'h6c;
        default: c = 8'h20;
      endcase
      return c;
    end
  endfunction

endpackage

[hw/rtl/telnet_receive_negotiator.sv]
// ----------------------------------------------------------------------------
// telnet_receive_negotiator
// telnet iac parser with option answers, line folding and ttype reply
// ----------------------------------------------------------------------------
// One received byte enters per item. After reset the option tables are
// cleared one entry per cycle, and the input stays stalled until the last
// entry is cleared. Bytes that cause at most one result, other than option
// bytes, are taken every cycle while the output is not stalled and no
// sequence plays out, with the result held in an output register while the
// next item is accepted. An option byte, the one after WILL, WONT, DO or
// DONT, waits for its registered table lookup before it is taken. A byte
// that causes n results (option triples, echo events, the terminal-type
// answer) then holds the input while a sequencer plays them out. The four
// option tables are held in two memories with registered reads.
module telnet_receive_negotiator
  import tnrn_pkg::*;
#(
  parameter int OPTION_COUNT  = 256,
  parameter int TERM_NAME_LEN = 15
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] destination,
  output logic [7:0] value,
  output logic       last
);

  localparam int IW = (OPTION_COUNT > 1) ? $clog2(OPTION_COUNT) : 1;
  localparam int TLEN = (TERM_NAME_LEN < NAME_MAX) ? TERM_NAME_LEN : NAME_MAX;
  localparam int SEQ_N = TLEN + 6;
  localparam int CW = $clog2(SEQ_N + 1);

  parse_state_t state, state_next;
  logic [7:0] cur_sub, cur_sub_next;
  logic       sub_ne, sub_ne_next;
  logic [7:0] sub_first, sub_first_next;

  // {sent will, received do} and {sent do, received will}
  logic [5:0] tab_a [OPTION_COUNT];
  logic [5:0] tab_b [OPTION_COUNT];
  logic [5:0] rd_a, rd_b;
  logic       lk_ok;
  logic       clr_busy;
  logic [IW-1:0] clr_idx;

  // pending multi-result sequence
  logic        busy;
  reply_kind_t kind;
  logic [7:0]  verb;
  logic [7:0]  opt;
  logic        pre_evt, post_evt;
  logic [7:0]  evt;
  logic [CW-1:0] idx, cnt;

  logic opt_state;
  assign opt_state = state inside {ST_WILL, ST_WONT, ST_DO, ST_DONT};

  logic take, adv;
  assign adv  = !out_valid || out_ready;
  assign in_ready = !busy && adv && !clr_busy && (!opt_state || lk_ok);
  assign take = in_valid && in_ready;

  // combinational decode of one byte
  logic       in_range;
  logic [IW-1:0] oi;
  logic [2:0] sw, rd, sd, rw;
  logic       do_ans;
  logic [7:0] ans_verb;
  logic [2:0] ans_code;
  logic       ans_emit;
  logic       wr_a, wr_b;
  logic [2:0] wa_sw, wa_rd, wb_sd, wb_rw;
  logic       d_pre, d_post, d_ttype;
  logic [7:0] d_evt;
  logic       d_single;
  logic [1:0] s_dest;
  logic [7:0] s_val;

  logic ttype_hit;
  assign ttype_hit = cur_sub == 8'd24 && sub_ne && sub_first == 8'd1;

  always_comb begin
    in_range = {24'd0, rx_byte} < OPTION_COUNT;
    oi = IW'(rx_byte);
    sw = in_range ? rd_a[5:3] : E_NONE;
    rd = in_range ? rd_a[2:0] : E_NONE;
    sd = in_range ? rd_b[5:3] : E_NONE;
    rw = in_range ? rd_b[2:0] : E_NONE;
  end

  always_comb begin
    state_next = state;
    cur_sub_next = cur_sub;
    sub_ne_next = sub_ne;
    sub_first_next = sub_first;
    do_ans = 1'b0;
    ans_verb = B_DO;
    d_pre = 1'b0;
    d_post = 1'b0;
    d_evt = EVT_EOR;
    d_ttype = 1'b0;
    d_single = 1'b0;
    s_dest = DEST_APP;
    s_val = rx_byte;
    wr_a = 1'b0;
    wr_b = 1'b0;
    wa_sw = E_NONE;
    wa_rd = E_NONE;
    wb_sd = E_NONE;
    wb_rw = E_NONE;
    case (state)
      ST_DATA: begin
        if (rx_byte == B_IAC) state_next = ST_IAC;
        else if (rx_byte == B_CR) state_next = ST_DATAR;
        else if (rx_byte == B_LF) state_next = ST_DATAN;
        else d_single = 1'b1;
      end
      ST_DATAR, ST_DATAN: begin
        if (rx_byte == B_IAC) state_next = ST_IAC;
        else begin
          state_next = ST_DATA;
          d_single = 1'b1;
          if (rx_byte == B_CR || rx_byte == B_LF) s_val = B_LF;
        end
      end
      ST_IAC: begin
        state_next = ST_DATA;
        if (rx_byte == B_IAC) d_single = 1'b1;
        else if (rx_byte == B_WILL) state_next = ST_WILL;
        else if (rx_byte == B_WONT) state_next = ST_WONT;
        else if (rx_byte == B_DONT) state_next = ST_DONT;
        else if (rx_byte == B_DO) state_next = ST_DO;
        else if (rx_byte == B_EOR) begin
          d_single = 1'b1;
          s_dest = DEST_EVT;
          s_val = EVT_EOR;
        end else if (rx_byte == B_SB) begin
          state_next = ST_SB;
          sub_ne_next = 1'b0;
          sub_first_next = 8'd0;
        end
      end
      ST_WILL: begin
        state_next = ST_DATA;
        do_ans = 1'b1;
        ans_verb = (rx_byte == 8'd0 || rx_byte == 8'd1 || rx_byte == 8'd3 ||
                    rx_byte == 8'd25) ? B_DO : B_DONT;
        d_pre = rx_byte == 8'd1;
        d_evt = EVT_ECHO_OFF;
      end
      ST_WONT: begin
        state_next = ST_DATA;
        do_ans = 1'b1;
        ans_verb = B_DONT;
        d_pre = rx_byte == 8'd1;
        d_evt = EVT_ECHO_ON;
      end
      ST_DO: begin
        state_next = ST_DATA;
        do_ans = 1'b1;
        ans_verb = (rx_byte == 8'd0 || rx_byte == 8'd1 || rx_byte == 8'd3 ||
                    rx_byte == 8'd24 || rx_byte == 8'd31) ? B_WILL : B_WONT;
        d_post = rx_byte == 8'd1;
        d_evt = EVT_ECHO_ON;
      end
      ST_DONT: begin
        state_next = ST_DATA;
        do_ans = 1'b1;
        ans_verb = B_WONT;
        d_post = rx_byte == 8'd1;
        d_evt = EVT_ECHO_OFF;
      end
      ST_SB: begin
        if (rx_byte == B_IAC) state_next = ST_SBIAC;
        else begin
          sub_ne_next = 1'b0;
          sub_first_next = 8'd0;
          cur_sub_next = rx_byte;
          state_next = ST_SBDATA;
        end
      end
      ST_SBDATA: begin
        if (rx_byte == B_IAC) state_next = ST_SBDATAIAC;
        else if (!sub_ne) begin
          sub_ne_next = 1'b1;
          sub_first_next = rx_byte;
        end
      end
      ST_SBIAC: begin
        if (rx_byte == B_IAC) begin
          sub_ne_next = 1'b0;
          sub_first_next = 8'd0;
          cur_sub_next = B_IAC;
        end
        state_next = ST_DATA;
      end
      ST_SBDATAIAC: begin
        if (rx_byte == B_IAC) begin
          state_next = ST_SBDATA;
          if (!sub_ne) begin
            sub_ne_next = 1'b1;
            sub_first_next = B_IAC;
          end
        end else begin
          if (rx_byte == B_SE || rx_byte == B_SB) d_ttype = ttype_hit;
          sub_ne_next = 1'b0;
          sub_first_next = 8'd0;
          if (rx_byte == B_SB) state_next = ST_SB;
          else begin
            state_next = ST_DATA;
            cur_sub_next = 8'd0;
          end
        end
      end
      default: state_next = ST_DATA;
    endcase

    case (ans_verb)
      B_DO:    ans_code = E_DO;
      B_DONT:  ans_code = E_DONT;
      B_WILL:  ans_code = E_WILL;
      default: ans_code = E_WONT;
    endcase
    if (ans_verb == B_DO || ans_verb == B_DONT)
      ans_emit = sw != ans_code || rd != ans_code;
    else
      ans_emit = sd != ans_code || rw != ans_code;
    if (state == ST_DO && rx_byte == 8'd31) begin
      ans_emit = 1'b1;
      wr_a = 1'b1;
      wa_sw = E_WILL;
      wa_rd = E_DO;
    end else if (do_ans && ans_emit) begin
      if (ans_verb == B_DO || ans_verb == B_DONT) begin
        wr_a = 1'b1;
        wa_sw = ans_code;
        wa_rd = ans_code;
      end else begin
        wr_b = 1'b1;
        wb_sd = ans_code;
        wb_rw = ans_code;
      end
    end
    ans_emit = ans_emit && do_ans;
  end

  // result count of the decoded byte
  logic [CW-1:0] n_res;
  always_comb begin
    if (d_ttype) n_res = CW'(SEQ_N);
    else n_res = CW'((ans_emit ? 3 : 0) + (d_pre ? 1 : 0) + (d_post ? 1 : 0));
  end

  // current element of a running sequence
  logic [1:0] q_dest;
  logic [7:0] q_val;
  logic [CW-1:0] k;
  always_comb begin
    q_dest = DEST_NET;
    q_val = B_IAC;
    k = idx;
    if (kind == RPL_TTYPE) begin
      if (idx == CW'(0)) q_val = B_IAC;
      else if (idx == CW'(1)) q_val = B_SB;
      else if (idx == CW'(2)) q_val = 8'd24;
      else if (idx == CW'(3)) q_val = 8'd0;
      else if (idx == CW'(SEQ_N - 2)) q_val = B_IAC;
      else if (idx == CW'(SEQ_N - 1)) q_val = B_SE;
      else q_val = term_char(6'(idx - CW'(4)));
    end else begin
      if (pre_evt) begin
        if (idx == CW'(0)) begin
          q_dest = DEST_EVT;
          q_val = evt;
        end
        k = idx - CW'(1);
      end
      if (k == CW'(0)) q_val = B_IAC;
      else if (k == CW'(1)) q_val = verb;
      else if (k == CW'(2)) q_val = opt;
      if (post_evt && idx == cnt - CW'(1)) begin
        q_dest = DEST_EVT;
        q_val = evt;
      end
    end
  end

  // option tables, cleared one entry per cycle after reset
  always_ff @(posedge clk) begin
    if (clr_busy) begin
      tab_a[clr_idx] <= '0;
      tab_b[clr_idx] <= '0;
    end else if (take && in_range) begin
      if (wr_a) tab_a[oi] <= {wa_sw, wa_rd};
      if (wr_b) tab_b[oi] <= {wb_sd, wb_rw};
    end
    rd_a <= tab_a[oi];
    rd_b <= tab_b[oi];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_idx <= '0;
      lk_ok <= 1'b0;
    end else begin
      if (clr_busy) begin
        clr_idx <= clr_idx + IW'(1);
        if (clr_idx == IW'(OPTION_COUNT - 1)) clr_busy <= 1'b0;
      end
      lk_ok <= opt_state && in_valid && !take && !clr_busy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_DATA;
      cur_sub <= 8'd0;
      sub_ne <= 1'b0;
      sub_first <= 8'd0;
      busy <= 1'b0;
      out_valid <= 1'b0;
      kind <= RPL_NONE;
      idx <= '0;
      cnt <= '0;
    end else begin
      if (adv) begin
        if (busy) begin
          out_valid <= 1'b1;
          destination <= q_dest;
          value <= q_val;
          last <= idx == cnt - CW'(1);
          idx <= idx + CW'(1);
          if (idx == cnt - CW'(1)) begin
            busy <= 1'b0;
            kind <= RPL_NONE;
          end
        end else begin
          out_valid <= take && d_single;
        end
      end
      if (take) begin
        state <= state_next;
        cur_sub <= cur_sub_next;
        sub_ne <= sub_ne_next;
        sub_first <= sub_first_next;
        if (d_single) begin
          destination <= s_dest;
          value <= s_val;
          last <= 1'b1;
        end else if (n_res != CW'(0)) begin
          busy <= 1'b1;
          kind <= d_ttype ? RPL_TTYPE : RPL_OPT;
          verb <= ans_verb;
          opt <= rx_byte;
          pre_evt <= d_pre;
          post_evt <= d_post;
          evt <= d_evt;
          cnt <= n_res;
          idx <= '0;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !in_ready) else $error("input taken during sequence");
  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    busy |-> idx < cnt) else $error("sequence index overrun");
  a_kind_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> kind != RPL_NONE) else $error("sequence without kind");
  a_single_last: assert property (@(posedge clk) disable iff (rst)
    (take && d_single) |=> (out_valid && last)) else $error("single result not last");
  a_clear_hold: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !in_ready) else $error("input taken while tables clear");
  a_lookup_ready: assert property (@(posedge clk) disable iff (rst)
    (take && opt_state) |-> lk_ok) else $error("option taken before lookup");
`endif

endmodule

[tb/sv/telnet_receive_negotiator_tb.sv]
// ----------------------------------------------------------------------------
// telnet_receive_negotiator_tb
// self-checking bench for the telnet receive negotiator
// ----------------------------------------------------------------------------
// A short directed table walks data, line folding, every IAC verb, the echo
// events, the NAWS and terminal-type answers and the malformed command paths.
// Random telnet traffic follows. Every accepted byte runs through a local
// predictor, and each output item is compared with the oldest prediction.
// Both handshakes idle at random, the receiver holds off for a long stretch
// once, and the sender pauses once until all predicted items have drained.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module telnet_receive_negotiator_tb;
  import tnrn_pkg::*;

  localparam int OPT_COUNT = 256;
  localparam int NAME_LEN  = 15;
  localparam int WDOG_LIMIT = 6000;

  typedef struct packed {
    logic [1:0] dest;
    logic [7:0] val;
    logic       lst;
  } rx_result_t;

  typedef struct {
    logic [7:0] b;
    bit         typed;
    logic [1:0] dest;
    logic [7:0] val;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] destination;
  logic [7:0] value;
  logic       last;

  telnet_receive_negotiator #(
    .OPTION_COUNT (OPT_COUNT),
    .TERM_NAME_LEN(NAME_LEN)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .destination(destination),
    .value      (value),
    .last       (last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  parse_state_t pst;
  logic [7:0]   sub_opt;
  logic         sub_has;
  logic [7:0]   sub_first;
  logic [2:0]   will_sent [OPT_COUNT];
  logic [2:0]   do_rcvd   [OPT_COUNT];
  logic [2:0]   do_sent   [OPT_COUNT];
  logic [2:0]   will_rcvd [OPT_COUNT];

  rx_result_t expected_q[$];
  rx_result_t burst_q[$];
  logic [7:0] stim_q[$];
  dir_row_t   dir_rows[$];

  int  errors = 0;
  int  idle_cycles = 0;
  bit  hold_req = 1'b0;

  task automatic put(input logic [1:0] d, input logic [7:0] v);
    rx_result_t r;
    r.dest = d;
    r.val = v;
    r.lst = 1'b0;
    burst_q.push_back(r);
  endtask

  task automatic answer_option(input logic [7:0] opt, input logic [7:0] verb);
    logic [2:0] code;
    bit         dir_do;
    bit         fresh;
    begin
      dir_do = (verb == B_DO) || (verb == B_DONT);
      code = (verb == B_DO) ? E_DO : (verb == B_DONT) ? E_DONT :
             (verb == B_WILL) ? E_WILL : E_WONT;
      if (dir_do) fresh = (will_sent[opt] != code) || (do_rcvd[opt] != code);
      else fresh = (do_sent[opt] != code) || (will_rcvd[opt] != code);
      if (fresh) begin
        put(DEST_NET, B_IAC);
        put(DEST_NET, verb);
        put(DEST_NET, opt);
        if (dir_do) begin
          will_sent[opt] = code;
          do_rcvd[opt] = code;
        end else begin
          do_sent[opt] = code;
          will_rcvd[opt] = code;
        end
      end
    end
  endtask

  task automatic sub_keep(input logic [7:0] b);
    if (!sub_has) begin
      sub_has = 1'b1;
      sub_first = b;
    end
  endtask

  task automatic ttype_reply_check();
    if (sub_opt == 8'd24 && sub_has && sub_first == 8'd1) begin
      put(DEST_NET, B_IAC);
      put(DEST_NET, B_SB);
      put(DEST_NET, 8'd24);
      put(DEST_NET, 8'd0);
      for (int i = 0; i < NAME_LEN; i++) begin
        case (i)
          0: put(DEST_NET, "S");
          1: put(DEST_NET, "i");
          2: put(DEST_NET, "r");
          3: put(DEST_NET, "a");
          4: put(DEST_NET, "g");
          5: put(DEST_NET, "g");
          6: put(DEST_NET, "a");
          7: put(DEST_NET, "T");
          8: put(DEST_NET, "e");
          9: put(DEST_NET, "r");
          10: put(DEST_NET, "m");
          11: put(DEST_NET, "i");
          12: put(DEST_NET, "n");
          13: put(DEST_NET, "a");
          14: put(DEST_NET, "l");
          default: put(DEST_NET, 8'h20);
        endcase
      end
      put(DEST_NET, B_IAC);
      put(DEST_NET, B_SE);
    end
  endtask

  // works out the items one received byte causes, into burst_q
  task automatic parse_byte(input logic [7:0] b);
    burst_q.delete();
    case (pst)
      ST_DATA: begin
        if (b == B_IAC) pst = ST_IAC;
        else if (b == B_CR) pst = ST_DATAR;
        else if (b == B_LF) pst = ST_DATAN;
        else put(DEST_APP, b);
      end
      ST_DATAR, ST_DATAN: begin
        if (b == B_IAC) pst = ST_IAC;
        else begin
          put(DEST_APP, (b == B_CR || b == B_LF) ? B_LF : b);
          pst = ST_DATA;
        end
      end
      ST_IAC: begin
        pst = ST_DATA;
        if (b == B_IAC) put(DEST_APP, B_IAC);
        else if (b == B_WILL) pst = ST_WILL;
        else if (b == B_WONT) pst = ST_WONT;
        else if (b == B_DONT) pst = ST_DONT;
        else if (b == B_DO) pst = ST_DO;
        else if (b == B_EOR) put(DEST_EVT, EVT_EOR);
        else if (b == B_SB) begin
          pst = ST_SB;
          sub_has = 1'b0;
          sub_first = 8'd0;
        end
      end
      ST_WILL: begin
        if (b == 8'd1) put(DEST_EVT, EVT_ECHO_OFF);
        if (b == 8'd0 || b == 8'd1 || b == 8'd3 || b == 8'd25) answer_option(b, B_DO);
        else answer_option(b, B_DONT);
        pst = ST_DATA;
      end
      ST_WONT: begin
        if (b == 8'd1) put(DEST_EVT, EVT_ECHO_ON);
        answer_option(b, B_DONT);
        pst = ST_DATA;
      end
      ST_DO: begin
        if (b == 8'd31) begin
          do_rcvd[b] = E_DO;
          will_sent[b] = E_WILL;
          put(DEST_NET, B_IAC);
          put(DEST_NET, B_WILL);
          put(DEST_NET, b);
        end else if (b == 8'd0 || b == 8'd1 || b == 8'd3 || b == 8'd24) begin
          answer_option(b, B_WILL);
          if (b == 8'd1) put(DEST_EVT, EVT_ECHO_ON);
        end else answer_option(b, B_WONT);
        pst = ST_DATA;
      end
      ST_DONT: begin
        answer_option(b, B_WONT);
        if (b == 8'd1) put(DEST_EVT, EVT_ECHO_OFF);
        pst = ST_DATA;
      end
      ST_SB: begin
        if (b == B_IAC) pst = ST_SBIAC;
        else begin
          sub_has = 1'b0;
          sub_first = 8'd0;
          sub_opt = b;
          pst = ST_SBDATA;
        end
      end
      ST_SBDATA: begin
        if (b == B_IAC) pst = ST_SBDATAIAC;
        else sub_keep(b);
      end
      ST_SBIAC: begin
        if (b == B_IAC) begin
          sub_has = 1'b0;
          sub_first = 8'd0;
          sub_opt = B_IAC;
        end
        pst = ST_DATA;
      end
      ST_SBDATAIAC: begin
        if (b == B_IAC) begin
          pst = ST_SBDATA;
          sub_keep(B_IAC);
        end else if (b == B_SE || b == B_SB) begin
          ttype_reply_check();
          if (b == B_SE) sub_opt = 8'd0;
          sub_has = 1'b0;
          sub_first = 8'd0;
          pst = (b == B_SE) ? ST_DATA : ST_SB;
        end else begin
          sub_has = 1'b0;
          sub_first = 8'd0;
          sub_opt = 8'd0;
          pst = ST_DATA;
        end
      end
      default: pst = ST_DATA;
    endcase
    if (burst_q.size() > 0) burst_q[burst_q.size() - 1].lst = 1'b1;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit typed,
                           input logic [1:0] d, input logic [7:0] v);
    int gap;
    rx_result_t r;
    begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      in_valid = 1'b1;
      rx_byte = b;
      do @(posedge clk); while (!in_ready);
      parse_byte(b);
      if (typed) begin
        r.dest = d;
        r.val = v;
        r.lst = 1'b1;
        expected_q.push_back(r);
      end else begin
        foreach (burst_q[i]) expected_q.push_back(burst_q[i]);
      end
      @(negedge clk);
    end
  endtask

  task automatic add_row(input logic [7:0] b, input bit typed = 1'b0,
                         input logic [1:0] d = DEST_APP, input logic [7:0] v = 8'd0);
    dir_row_t row;
    row.b = b;
    row.typed = typed;
    row.dest = d;
    row.val = v;
    dir_rows.push_back(row);
  endtask

  function automatic logic [7:0] pick_option();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd3;
      3: return 8'd24;
      4: return 8'd25;
      5: return 8'd31;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic gen_sequence();
    logic [7:0] x;
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        x = 8'($urandom_range(0, 255));
        stim_q.push_back(x);
        if (x == B_IAC) stim_q.push_back(B_IAC);
      end
      3: begin
        stim_q.push_back($urandom_range(0, 1) ? B_CR : B_LF);
        case ($urandom_range(0, 2))
          0: stim_q.push_back($urandom_range(0, 1) ? B_CR : B_LF);
          1: stim_q.push_back(8'($urandom_range(32, 126)));
          default: ;
        endcase
      end
      4, 5, 6: begin
        stim_q.push_back(B_IAC);
        case ($urandom_range(0, 3))
          0: stim_q.push_back(B_WILL);
          1: stim_q.push_back(B_WONT);
          2: stim_q.push_back(B_DO);
          default: stim_q.push_back(B_DONT);
        endcase
        stim_q.push_back(pick_option());
      end
      7: begin
        stim_q.push_back(B_IAC);
        stim_q.push_back(B_SB);
        stim_q.push_back(($urandom_range(0, 3) != 0) ? 8'd24 : pick_option());
        stim_q.push_back(($urandom_range(0, 3) != 0) ? 8'd1 : 8'($urandom_range(0, 255)));
        n = $urandom_range(0, 3);
        repeat (n) stim_q.push_back(8'($urandom_range(0, 255)));
        stim_q.push_back(B_IAC);
        case ($urandom_range(0, 3))
          0: stim_q.push_back(B_SB);
          1: stim_q.push_back(8'($urandom_range(0, 255)));
          default: stim_q.push_back(B_SE);
        endcase
      end
      8: begin
        stim_q.push_back(B_IAC);
        if ($urandom_range(0, 2) == 0) begin
          stim_q.push_back(B_SB);
          stim_q.push_back(B_IAC);
        end
        stim_q.push_back(8'($urandom_range(0, 255)));
      end
      default: stim_q.push_back(8'($urandom_range(0, 255)));
    endcase
  endtask

  // output side: random stall per item, plus one long hold-off on request
  initial begin
    rx_result_t exp_r;
    int stall;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      do @(posedge clk); while (!out_valid);
      if (expected_q.size() == 0) begin
        $error("unexpected item dest=%0d value=%0d last=%0d", destination, value, last);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (destination !== exp_r.dest) begin
          $error("destination expected %0d actual %0d", exp_r.dest, destination);
          errors++;
        end
        if (value !== exp_r.val) begin
          $error("value expected %0d actual %0d", exp_r.val, value);
          errors++;
        end
        if (last !== exp_r.lst) begin
          $error("last expected %0d actual %0d", exp_r.lst, last);
          errors++;
        end
      end
      @(negedge clk);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    pst = ST_DATA;
    sub_opt = 8'd0;
    sub_has = 1'b0;
    sub_first = 8'd0;
    for (int i = 0; i < OPT_COUNT; i++) begin
      will_sent[i] = E_NONE;
      do_rcvd[i] = E_NONE;
      do_sent[i] = E_NONE;
      will_rcvd[i] = E_NONE;
    end

    add_row(8'h41, 1'b1, DEST_APP, 8'h41);
    add_row(8'h00, 1'b1, DEST_APP, 8'h00);
    add_row(8'hfe, 1'b1, DEST_APP, 8'hfe);
    add_row(B_CR);
    add_row(B_LF, 1'b1, DEST_APP, B_LF);
    add_row(B_LF);
    add_row(8'h78, 1'b1, DEST_APP, 8'h78);
    add_row(B_CR);
    add_row(B_IAC);
    add_row(B_IAC, 1'b1, DEST_APP, B_IAC);
    add_row(B_IAC);
    add_row(B_EOR, 1'b1, DEST_EVT, EVT_EOR);
    add_row(B_IAC); add_row(B_WILL); add_row(8'd1);
    add_row(B_IAC); add_row(B_WILL); add_row(8'd1);
    add_row(B_IAC); add_row(B_WONT); add_row(8'd1);
    add_row(B_IAC); add_row(B_DO); add_row(8'd1);
    add_row(B_IAC); add_row(B_DONT); add_row(8'd1);
    add_row(B_IAC); add_row(B_DO); add_row(8'd31);
    add_row(B_IAC); add_row(B_DO); add_row(8'd31);
    add_row(B_IAC); add_row(B_WILL); add_row(8'd255);
    add_row(B_IAC); add_row(B_SB); add_row(8'd24); add_row(8'd1);
    add_row(B_IAC); add_row(B_SE);
    add_row(B_IAC); add_row(8'h80);
    add_row(B_IAC); add_row(B_SB); add_row(B_IAC); add_row(B_IAC);
    add_row(B_IAC); add_row(B_SB); add_row(B_IAC); add_row(8'h33);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].dest, dir_rows[i].val);

    while (stim_q.size() < 500) gen_sequence();
    for (int i = 0; i < stim_q.size(); i++) begin
      if (i == 150) hold_req = 1'b1;
      if (i == 300) begin
        in_valid = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
      end
      send_byte(stim_q[i], 1'b0, DEST_APP, 8'd0);
    end
    in_valid = 1'b0;

    while (expected_q.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
